>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define PIDC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pidc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidc assertion failed");

`else

`define PIDC_ASSERT(lbl, clk, rst, prop)
`define PIDC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Types and constants of the positional PID controller with clamps.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Default depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic signed [15:0] pidc_sample_t;
  typedef logic signed [15:0] pidc_gain_t;
  typedef logic [14:0]        pidc_limit_t;
  typedef logic signed [16:0] pidc_err_t;
  typedef logic signed [17:0] pidc_derr_t;
  typedef logic signed [24:0] pidc_acc_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } pidc_reg_t;

  // Error and error step of one word, handed from front to back end.
  typedef struct packed {
    pidc_err_t  err;
    pidc_derr_t derr;
  } pidc_item_t;

  typedef struct packed {
    pidc_gain_t  prop_gain;
    pidc_gain_t  integ_gain;
    pidc_gain_t  deriv_gain;
    pidc_limit_t integ_limit;
    pidc_limit_t drive_limit;
  } pidc_cfg_t;

endpackage

>>> rtl/pidc_if.sv
// ----------------------------------------------------------------------------
// pidc interfaces
// Valid/ready channels for samples, drive words and register writes.
// ----------------------------------------------------------------------------
interface pidc_in_if;
  import pidc_pkg::*;
  logic         valid;
  logic         ready;
  pidc_sample_t target;
  pidc_sample_t measured;
  modport source (output valid, output target, output measured, input ready);
  modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidc_out_if;
  import pidc_pkg::*;
  logic         valid;
  logic         ready;
  pidc_sample_t drive;
  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

interface pidc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/positional_pid_with_clamps_top.sv
// ----------------------------------------------------------------------------
// positional_pid_with_clamps_top
// Positional PID controller with clamped integral and clamped drive.
// ----------------------------------------------------------------------------
// Channels: sample carries target and measured (signed 16 bits) as one word;
// result carries the signed 16-bit drive, one word per sample, in order.
// cfg writes the registers: 0 prop_gain, 1 integ_gain, 2 deriv_gain (Q8.8),
// 3 integ_limit, 4 drive_limit (15 bits). Other indexes are ignored; cfg is
// always ready and should be written only while no sample is in flight.
// An accepted sample passes the queue, the product stage, the integral stage
// and the output register before its drive word is valid.
// Throughput: one sample per cycle while the receiver takes drive words, set
// by the integral accumulate and clamp that each word passes through in order.
// A two-word queue sits between the error front end and the arithmetic back
// end. When the receiver stalls, the back end holds and the queue fills;
// sample.ready falls only once the queue is full.
// Reset clears the last error and the integral, sets the gains to zero and
// both limits to 32767, and empties the queue and pipeline.
// ----------------------------------------------------------------------------
module positional_pid_with_clamps_top #(
  parameter int unsigned QueueDepth = pidc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  pidc_in_if.sink    sample,
  pidc_out_if.source result,
  pidc_cfg_if.sink   cfg
);
  import pidc_pkg::*;

  pidc_cfg_t  cfg_regs;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  pidc_item_t q_wdata;
  pidc_item_t q_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.prop_gain   <= '0;
      cfg_regs.integ_gain  <= '0;
      cfg_regs.deriv_gain  <= '0;
      cfg_regs.integ_limit <= '1;
      cfg_regs.drive_limit <= '1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:   cfg_regs.prop_gain   <= cfg.data;
        REG_INTEG_GAIN:  cfg_regs.integ_gain  <= cfg.data;
        REG_DERIV_GAIN:  cfg_regs.deriv_gain  <= cfg.data;
        REG_INTEG_LIMIT: cfg_regs.integ_limit <= cfg.data[14:0];
        REG_DRIVE_LIMIT: cfg_regs.drive_limit <= cfg.data[14:0];
        default: begin
        end
      endcase
    end
  end

  pidc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  pidc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  pidc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

>>> rtl/pidc_front.sv
// ----------------------------------------------------------------------------
// pidc_front
// Accepts samples, forms the error and its step against the last error.
// ----------------------------------------------------------------------------
module pidc_front (
  input  logic                 clk,
  input  logic                 rst,
  pidc_in_if.sink              sample,
  input  logic                 q_full,
  output logic                 q_push,
  output pidc_pkg::pidc_item_t q_data
);
  import pidc_pkg::*;

  pidc_err_t prev_error;
  pidc_err_t err;

  assign err          = pidc_err_t'(sample.target) - pidc_err_t'(sample.measured);
  assign sample.ready = !q_full;
  assign q_push       = sample.valid && !q_full;
  assign q_data.err   = err;
  assign q_data.derr  = pidc_derr_t'(err) - pidc_derr_t'(prev_error);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (q_push) begin
      prev_error <= err;
    end
  end

endmodule

>>> rtl/pidc_fifo.sv
// ----------------------------------------------------------------------------
// pidc_fifo
// Short queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidc_fifo #(
  parameter int unsigned Depth = pidc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pidc_pkg::pidc_item_t push_data,
  output logic                 full,
  input  logic                 pop,
  output pidc_pkg::pidc_item_t pop_data,
  output logic                 empty
);
  import pidc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pidc_item_t       slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PIDC_ASSERT(a_count_bound, clk, rst, count <= CntW'(Depth))
  `PIDC_ASSERT(a_no_pop_empty, clk, rst, !(pop && empty))
  `PIDC_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

>>> rtl/pidc_back.sv
// ----------------------------------------------------------------------------
// pidc_back
// Gain products, clamped integral, term sum and drive clamp, three stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pidc_pkg::pidc_cfg_t  cfg,
  input  logic                 q_empty,
  input  pidc_pkg::pidc_item_t q_data,
  output logic                 q_pop,
  pidc_out_if.source           result
);
  import pidc_pkg::*;

  // Stage 1: products of gains and error terms.
  logic               s1_valid;
  logic signed [32:0] s1_p;
  logic signed [32:0] s1_i;
  logic signed [33:0] s1_d;

  // Stage 2: integral state and the P plus D sum.
  logic               s2_valid;
  logic signed [34:0] s2_pd;
  pidc_acc_t          integ_acc;

  // Output register.
  logic               o_valid;
  pidc_sample_t       o_drive;

  logic               en;
  logic signed [32:0] p_prod;
  logic signed [32:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [33:0] acc_sum;
  logic signed [33:0] acc_bound;
  pidc_acc_t          integ_acc_next;
  logic signed [35:0] total;
  logic signed [27:0] shifted;
  pidc_sample_t       drv_lim;
  pidc_sample_t       drive_next;

  // The whole back end advances whenever the output word is free or taken.
  assign en    = !o_valid || result.ready;
  assign q_pop = en && !q_empty;

  assign p_prod = 33'(cfg.prop_gain) * 33'(q_data.err);
  assign i_prod = 33'(cfg.integ_gain) * 33'(q_data.err);
  assign d_prod = 34'(cfg.deriv_gain) * 34'(q_data.derr);

  always_comb begin
    acc_sum   = 34'(integ_acc) + 34'(s1_i);
    acc_bound = $signed({11'd0, cfg.integ_limit, 8'd0});
    if (acc_sum > acc_bound) begin
      integ_acc_next = acc_bound[24:0];
    end else if (acc_sum < -acc_bound) begin
      integ_acc_next = 25'(-acc_bound);
    end else begin
      integ_acc_next = acc_sum[24:0];
    end
  end

  always_comb begin
    total   = 36'(s2_pd) + 36'(integ_acc);
    // Arithmetic shift rounds toward minus infinity.
    shifted = total[35:8];
    drv_lim = $signed({1'b0, cfg.drive_limit});
    if (shifted > 28'(drv_lim)) begin
      drive_next = drv_lim;
    end else if (shifted < -28'(drv_lim)) begin
      drive_next = -drv_lim;
    end else begin
      drive_next = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      o_valid   <= 1'b0;
      integ_acc <= '0;
    end else if (en) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
      o_valid  <= s2_valid;
      if (s1_valid) begin
        integ_acc <= integ_acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p    <= p_prod;
      s1_i    <= i_prod;
      s1_d    <= d_prod;
      s2_pd   <= 35'(s1_p) + 35'(s1_d);
      o_drive <= drive_next;
    end
  end

  assign result.valid = o_valid;
  assign result.drive = o_drive;

  `PIDC_ASSERT_NEXT(a_pop_fills_stage, clk, rst, q_pop, s1_valid)
  `PIDC_ASSERT(a_drive_not_min, clk, rst, !o_valid || (o_drive != 16'sh8000))
  `PIDC_ASSERT(a_drive_in_limit, clk, rst, !o_valid || ((o_drive <= drv_lim) && (o_drive >= -drv_lim)))

endmodule

>>> tb/sv/positional_pid_with_clamps_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_pid_with_clamps_top_tb
// Self-checking bench for the clamped positional PID controller. A short
// table of register writes and samples runs first, then phases of tracking,
// random and extreme samples under several gain and limit settings. Each
// drive word is compared with a typed value or a bit-exact software model.
// ----------------------------------------------------------------------------
module positional_pid_with_clamps_top_tb;
  import pidc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_ITEMS = 256;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   index;
    logic [15:0]  a;
    logic [15:0]  b;
    bit           typed;
    pidc_sample_t drive;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pidc_in_if  sample_if ();
  pidc_out_if result_if ();
  pidc_cfg_if cfg_if ();

  positional_pid_with_clamps_top u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always #2 clk = ~clk;

  // Controller model state and register copies.
  pidc_gain_t  kp, ki, kd;
  pidc_limit_t ilim, dlim;
  pidc_err_t   err_prev;
  pidc_acc_t   integ_q;

  pidc_sample_t drive_due[$];
  row_t         plan[$];
  int unsigned  faults = 0;
  int unsigned  sent_count = 0;
  int unsigned  next_hold = 700;
  int unsigned  cycles = 0;
  bit           quiet = 1'b0;
  int           plant_pos = 0;
  int           plant_goal = 0;

  function automatic pidc_sample_t predict_drive(pidc_sample_t tgt, pidc_sample_t meas);
    longint e, acc, bound, total, d;
    e = longint'(tgt) - longint'(meas);
    bound = longint'(ilim) * 256;
    acc = longint'(integ_q) + longint'(ki) * e;
    if (acc > bound) acc = bound;
    else if (acc < -bound) acc = -bound;
    total = longint'(kp) * e + acc + longint'(kd) * (e - longint'(err_prev));
    d = total >>> 8;
    if (d > longint'(dlim)) d = longint'(dlim);
    else if (d < -longint'(dlim)) d = -longint'(dlim);
    integ_q = acc[24:0];
    err_prev = e[16:0];
    return d[15:0];
  endfunction

  function automatic void store_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_PROP_GAIN:   kp = val;
      REG_INTEG_GAIN:  ki = val;
      REG_DERIV_GAIN:  kd = val;
      REG_INTEG_LIMIT: ilim = val[14:0];
      REG_DRIVE_LIMIT: dlim = val[14:0];
      default: ;
    endcase
  endfunction

  function automatic row_t wr(logic [2:0] idx, logic [15:0] val);
    return '{ROW_WRITE, idx, val, 16'h0000, 1'b0, 16'sd0};
  endfunction

  function automatic row_t smp(int tgt, int meas, bit typed = 1'b0, int want = 0);
    return '{ROW_SAMPLE, 3'd0, tgt[15:0], meas[15:0], typed, want[15:0]};
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Limits carry a random top bit, which the block must drop.
  function automatic logic [15:0] pick_limit();
    logic [15:0] top;
    top = {$urandom_range(1) == 1, 15'h0000};
    case ($urandom_range(4))
      0: return top;
      1: return top | 16'h7FFF;
      2: return top | 16'($urandom_range(100, 1));
      default: return top | 16'($urandom_range(32767));
    endcase
  endfunction

  // Stops offering samples and waits until every drive word has been taken.
  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    while (drive_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    store_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one word; a typed expectation replaces the modeled one but the
  // model still steps so that its state follows the block.
  task automatic send_sample(pidc_sample_t tgt, pidc_sample_t meas, bit typed,
                             pidc_sample_t want);
    pidc_sample_t modeled;
    while (!quiet && $urandom_range(99) < 11) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid    <= 1'b1;
    sample_if.target   <= tgt;
    sample_if.measured <= meas;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    modeled = predict_drive(tgt, meas);
    drive_due.push_back(typed ? want : modeled);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic next_pair(output pidc_sample_t tgt, output pidc_sample_t meas);
    int t, m, sel;
    sel = $urandom_range(9);
    if (sel < 7) begin
      // Closed-loop style: a held setpoint and a plant that creeps toward it.
      if ($urandom_range(31) == 0) plant_goal = int'($urandom_range(65535)) - 32768;
      plant_pos += (plant_goal - plant_pos) / 8 + int'($urandom_range(64)) - 32;
      if (plant_pos > 32767) plant_pos = 32767;
      if (plant_pos < -32768) plant_pos = -32768;
      t = plant_goal;
      m = plant_pos;
    end else if (sel < 9) begin
      t = int'($urandom_range(65535)) - 32768;
      m = int'($urandom_range(65535)) - 32768;
    end else begin
      t = ($urandom_range(1) == 1) ? 32767 : -32768;
      m = ($urandom_range(1) == 1) ? 32767 : -32768;
    end
    tgt  = t[15:0];
    meas = m[15:0];
  endtask

  // Result side: random stalls, plus long hold-offs while the sender keeps
  // offering words so that the internal queue fills and input ready drops.
  initial begin
    result_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sent_count >= next_hold) begin
        next_hold += 600;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          result_if.ready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        result_if.ready <= quiet || ($urandom_range(99) >= 11);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pidc_sample_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (drive_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected drive word %0d", result_if.drive);
      end else begin
        want = drive_due.pop_front();
        if (result_if.drive !== want) begin
          faults++;
          if (faults <= 10)
            $display("drive mismatch: expected %0d, got %0d", want, result_if.drive);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pidc_sample_t tgt, meas;
    logic [15:0]  g0, g1, g2, l0, l1;

    sample_if.valid    = 1'b0;
    sample_if.target   = '0;
    sample_if.measured = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    kp = '0; ki = '0; kd = '0;
    ilim = 15'h7FFF; dlim = 15'h7FFF;
    err_prev = '0; integ_q = '0;

    // Directed table. Rows with a typed drive follow directly from the
    // settings in force; the rest are left to the model.
    plan.push_back(smp(32767, -32768, 1'b1, 0));      // gains zero after reset
    plan.push_back(smp(-32768, 32767, 1'b1, 0));
    plan.push_back(wr(REG_PROP_GAIN, 16'h0100));      // unity proportional gain
    plan.push_back(smp(100, 0, 1'b1, 100));
    plan.push_back(smp(32767, -32768, 1'b1, 32767));  // drive clamps high
    plan.push_back(smp(-32768, 32767, 1'b1, -32767)); // and symmetrically low
    plan.push_back(wr(REG_DRIVE_LIMIT, 16'h0000));
    plan.push_back(smp(1000, 0, 1'b1, 0));            // zero drive limit
    plan.push_back(smp(0, 0, 1'b1, 0));
    plan.push_back(wr(REG_DRIVE_LIMIT, 16'h7FFF));
    plan.push_back(wr(REG_PROP_GAIN, 16'h8000));
    plan.push_back(wr(REG_INTEG_GAIN, 16'h7FFF));
    plan.push_back(wr(REG_DERIV_GAIN, 16'h7FFF));
    plan.push_back(wr(REG_INTEG_LIMIT, 16'h0000));    // integral pinned at zero
    plan.push_back(smp(32767, -32768));
    plan.push_back(smp(-32768, 32767));
    plan.push_back(smp(0, 0));
    plan.push_back(wr(REG_INTEG_LIMIT, 16'h7FFF));
    plan.push_back(wr(REG_INTEG_GAIN, 16'h8000));
    plan.push_back(wr(REG_PROP_GAIN, 16'h0000));
    plan.push_back(wr(REG_DERIV_GAIN, 16'h8000));
    plan.push_back(smp(32767, -32768));               // integral saturates
    plan.push_back(smp(32767, -32768));
    plan.push_back(smp(32767, -32768));
    plan.push_back(smp(-1, 0));
    plan.push_back(smp(1, -1));
    plan.push_back(wr(REG_SPARE_LO, 16'hFFFF));       // out-of-range index
    plan.push_back(wr(REG_SPARE_HI, 16'hFFFF));
    plan.push_back(wr(REG_INTEG_LIMIT, 16'hFFFF));    // top bit must be dropped
    plan.push_back(smp(-12345, 321));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(plan[i].index, plan[i].a);
      end else begin
        send_sample(plan[i].a, plan[i].b, plan[i].typed, plan[i].drive);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          g0 = 16'h0100; g1 = 16'h0010; g2 = 16'h0040; l0 = 16'd1000; l1 = 16'd2000;
        end
        1: begin
          g0 = 16'h7FFF; g1 = 16'h7FFF; g2 = 16'h8000; l0 = 16'h7FFF; l1 = 16'h7FFF;
        end
        2: begin
          g0 = pick_gain(); g1 = pick_gain(); g2 = pick_gain();
          l0 = 16'h0000; l1 = pick_limit();
        end
        default: begin
          g0 = pick_gain(); g1 = pick_gain(); g2 = pick_gain();
          l0 = pick_limit(); l1 = pick_limit();
        end
      endcase
      wait_drained();
      quiet = (phase == 1);
      write_reg(REG_PROP_GAIN, g0);
      write_reg(REG_INTEG_GAIN, g1);
      write_reg(REG_DERIV_GAIN, g2);
      write_reg(REG_INTEG_LIMIT, l0);
      write_reg(REG_DRIVE_LIMIT, l1);
      if (phase >= 3)
        write_reg($urandom_range(1) == 1 ? REG_SPARE_LO : REG_SPARE_HI,
                  16'($urandom_range(65535)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_pair(tgt, meas);
        send_sample(tgt, meas, 1'b0, 16'sd0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> positional_pid_with_clamps_top.f
+incdir+rtl
rtl/pidc_pkg.sv
rtl/pidc_if.sv
rtl/pidc_front.sv
rtl/pidc_fifo.sv
rtl/pidc_back.sv
rtl/positional_pid_with_clamps_top.sv
tb/sv/positional_pid_with_clamps_top_tb.sv
